// File: rtl/core/flr_pkg.sv
// Package with types, constants and field positions for the float literal recognizer.
`default_nettype none

package flr_pkg;

  // Character classes remembered from the previous accepted character.
  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_DIGIT,
    CLS_DOT,
    CLS_EXP,
    CLS_SIGN,
    CLS_SPACER,
    CLS_SUFFIX
  } char_class_t;

  // Field widths.
  localparam int CHAR_W = 8;
  localparam int SIG_W  = 64;
  localparam int FRAC_W = 8;
  localparam int EXPM_W = 16;

  // Output tdata layout, lowest bits first, padded to whole bytes.
  localparam int SIG_LSB    = 0;
  localparam int FRAC_LSB   = SIG_LSB + SIG_W;
  localparam int EXPNEG_BIT = FRAC_LSB + FRAC_W;
  localparam int EXPM_LSB   = EXPNEG_BIT + 1;
  localparam int OVF_BIT    = EXPM_LSB + EXPM_W;
  localparam int M_USED_W   = OVF_BIT + 1;
  localparam int M_DATA_W   = ((M_USED_W + 7) / 8) * 8;
  localparam int M_PAD_W    = M_DATA_W - M_USED_W;

  // Saturation limits.
  localparam logic [SIG_W-1:0]  SIG_LIMIT    = 64'd999999999999999999;
  localparam logic [SIG_W-1:0]  SIG_MAX      = 64'd9999999999999999999;
  localparam logic [EXPM_W-1:0] EXP_LIMIT    = 16'd6553;
  localparam logic [3:0]        EXP_LAST_DIG = 4'd5;
  localparam logic [EXPM_W-1:0] EXP_MAX      = 16'hFFFF;
  localparam logic [FRAC_W-1:0] FRAC_MAX     = 8'hFF;
  localparam logic [1:0]        SPACER_LIMIT = 2'd2;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_E_LC  = 8'h65;
  localparam logic [CHAR_W-1:0] CH_E_UC  = 8'h45;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_F_LC  = 8'h66;
  localparam logic [CHAR_W-1:0] CH_F_UC  = 8'h46;
  localparam logic [CHAR_W-1:0] CH_D_LC  = 8'h64;
  localparam logic [CHAR_W-1:0] CH_D_UC  = 8'h44;

endpackage

`default_nettype wire

// File: rtl/core/float_literal_recognizer.sv
// Top level of the float literal recognizer: character scanner and result register.
// The result of a string appears on m_tvalid in the cycle after its last beat is accepted.
// Throughput: one character beat per cycle; the scan state updates in a single pass
// whose longest path is the 64-bit multiply-by-ten and add of the significand.
// s_tready drops only while a finished result waits and m_tready is low.
// Reset (rst, synchronous, active high) clears the scan state and the output valid.
`default_nettype none

module float_literal_recognizer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [flr_pkg::CHAR_W-1:0]    s_tdata,  // [7:0] char_code
  input  logic                          s_tlast,  // is_last
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [63:0] significand, [71:64] fraction_digits, [72] exponent_negative,
  // [88:73] exponent_magnitude, [89] overflow, [95:90] zero
  output logic [flr_pkg::M_DATA_W-1:0]  m_tdata,
  output logic                          m_tuser   // valid_res
);
  import flr_pkg::*;

  // Scan state.
  logic              at_first_char, at_first_char_next;
  logic              in_fraction, in_fraction_next;
  logic              in_exponent, in_exponent_next;
  logic              dot_seen, dot_seen_next;
  logic              suffix_seen, suffix_seen_next;
  char_class_t       previous_class, previous_class_next;
  logic [1:0]        spacer_run, spacer_run_next;
  logic              failed, failed_next;
  logic              mantissa_digit_seen, mantissa_digit_seen_next;
  logic              exp_sign_negative, exp_sign_negative_next;
  logic [SIG_W-1:0]  digit_accumulator, digit_accumulator_next;
  logic [FRAC_W-1:0] fraction_count, fraction_count_next;
  logic [EXPM_W-1:0] exponent_accumulator, exponent_accumulator_next;
  logic              saturated, saturated_next;

  // Result register.
  logic              res_ok, res_ok_next;
  logic [M_DATA_W-1:0] res_data_next;

  logic              in_beat;
  logic              is_digit;
  logic [3:0]        digit_val;
  logic [CHAR_W-1:0] digit_off;
  logic [SIG_W-1:0]  sig_times_ten;
  logic [EXPM_W-1:0] exp_times_ten;
  logic              sig_over;
  logic              exp_over;

  // The input side stalls only when the output register is full and held.
  assign s_tready = !m_tvalid || m_tready;
  assign in_beat  = s_tvalid && s_tready;

  // Digit decode and the multiply-by-ten datapaths.
  assign is_digit      = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
  assign digit_off     = s_tdata - CH_ZERO;
  assign digit_val     = digit_off[3:0];
  assign sig_times_ten = (digit_accumulator << 3) + (digit_accumulator << 1)
                         + {{(SIG_W-4){1'b0}}, digit_val};
  assign exp_times_ten = (exponent_accumulator << 3) + (exponent_accumulator << 1)
                         + {{(EXPM_W-4){1'b0}}, digit_val};
  assign sig_over      = digit_accumulator > SIG_LIMIT;
  assign exp_over      = (exponent_accumulator > EXP_LIMIT) ||
                         ((exponent_accumulator == EXP_LIMIT) && (digit_val > EXP_LAST_DIG));

  // Next scan state for one character.
  always_comb begin
    at_first_char_next        = at_first_char;
    in_fraction_next          = in_fraction;
    in_exponent_next          = in_exponent;
    dot_seen_next             = dot_seen;
    suffix_seen_next          = suffix_seen;
    previous_class_next       = previous_class;
    spacer_run_next           = spacer_run;
    failed_next               = failed;
    mantissa_digit_seen_next  = mantissa_digit_seen;
    exp_sign_negative_next    = exp_sign_negative;
    digit_accumulator_next    = digit_accumulator;
    fraction_count_next       = fraction_count;
    exponent_accumulator_next = exponent_accumulator;
    saturated_next            = saturated;

    if (!failed) begin
      priority if (is_digit) begin
        if (in_exponent) begin
          if (exp_over) begin
            exponent_accumulator_next = EXP_MAX;
            saturated_next            = 1'b1;
          end else begin
            exponent_accumulator_next = exp_times_ten;
          end
        end else begin
          mantissa_digit_seen_next = 1'b1;
          if (sig_over) begin
            digit_accumulator_next = SIG_MAX;
            saturated_next         = 1'b1;
          end else begin
            digit_accumulator_next = sig_times_ten;
          end
          if (in_fraction) begin
            if (fraction_count == FRAC_MAX) begin
              saturated_next = 1'b1;
            end else begin
              fraction_count_next = fraction_count + 1'b1;
            end
          end
        end
        spacer_run_next     = '0;
        previous_class_next = CLS_DIGIT;
      end else if (s_tdata == CH_DOT) begin
        if (dot_seen || in_exponent || previous_class == CLS_SPACER) begin
          failed_next = 1'b1;
        end else begin
          dot_seen_next       = 1'b1;
          in_fraction_next    = 1'b1;
          previous_class_next = CLS_DOT;
        end
      end else if ((s_tdata == CH_E_LC) || (s_tdata == CH_E_UC)) begin
        if (in_exponent || previous_class == CLS_SPACER || at_first_char || s_tlast) begin
          failed_next = 1'b1;
        end else begin
          in_exponent_next    = 1'b1;
          in_fraction_next    = 1'b0;
          previous_class_next = CLS_EXP;
        end
      end else if ((s_tdata == CH_MINUS) || (s_tdata == CH_PLUS)) begin
        if (previous_class != CLS_EXP || s_tlast) begin
          failed_next = 1'b1;
        end else begin
          exp_sign_negative_next = (s_tdata == CH_MINUS);
          previous_class_next    = CLS_SIGN;
        end
      end else if (s_tdata == CH_UNDER) begin
        if (at_first_char || s_tlast || previous_class == CLS_DOT ||
            previous_class == CLS_EXP || previous_class == CLS_SIGN ||
            spacer_run >= SPACER_LIMIT) begin
          failed_next = 1'b1;
        end else begin
          spacer_run_next     = spacer_run + 1'b1;
          previous_class_next = CLS_SPACER;
        end
      end else if ((s_tdata == CH_F_LC) || (s_tdata == CH_F_UC) ||
                   (s_tdata == CH_D_LC) || (s_tdata == CH_D_UC)) begin
        if (!s_tlast || previous_class == CLS_SPACER || previous_class == CLS_EXP ||
            previous_class == CLS_SIGN) begin
          failed_next = 1'b1;
        end else begin
          suffix_seen_next    = 1'b1;
          previous_class_next = CLS_SUFFIX;
        end
      end else begin
        failed_next = 1'b1;
      end
    end
    at_first_char_next = 1'b0;

    // Result of the string, judged on the state after its last character.
    res_ok_next = !failed_next && mantissa_digit_seen_next &&
                  (dot_seen_next || in_exponent_next || suffix_seen_next);
    res_data_next = '0;
    if (res_ok_next) begin
      res_data_next = {{M_PAD_W{1'b0}}, saturated_next, exponent_accumulator_next,
                       exp_sign_negative_next, fraction_count_next,
                       digit_accumulator_next};
    end
  end

  // Scan state register; the end of a string returns everything to reset values.
  always_ff @(posedge clk) begin
    if (rst || (in_beat && s_tlast)) begin
      at_first_char        <= 1'b1;
      in_fraction          <= 1'b0;
      in_exponent          <= 1'b0;
      dot_seen             <= 1'b0;
      suffix_seen          <= 1'b0;
      previous_class       <= CLS_NONE;
      spacer_run           <= '0;
      failed               <= 1'b0;
      mantissa_digit_seen  <= 1'b0;
      exp_sign_negative    <= 1'b0;
      digit_accumulator    <= '0;
      fraction_count       <= '0;
      exponent_accumulator <= '0;
      saturated            <= 1'b0;
    end else if (in_beat) begin
      at_first_char        <= at_first_char_next;
      in_fraction          <= in_fraction_next;
      in_exponent          <= in_exponent_next;
      dot_seen             <= dot_seen_next;
      suffix_seen          <= suffix_seen_next;
      previous_class       <= previous_class_next;
      spacer_run           <= spacer_run_next;
      failed               <= failed_next;
      mantissa_digit_seen  <= mantissa_digit_seen_next;
      exp_sign_negative    <= exp_sign_negative_next;
      digit_accumulator    <= digit_accumulator_next;
      fraction_count       <= fraction_count_next;
      exponent_accumulator <= exponent_accumulator_next;
      saturated            <= saturated_next;
    end
  end

  // Output valid: set by a last beat, cleared when the result beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_beat && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (in_beat && s_tlast) begin
      res_ok  <= res_ok_next;
      m_tdata <= res_data_next;
    end
  end

  assign m_tuser = res_ok;

endmodule

`default_nettype wire

// File: rtl/core/flr_checker.sv
// Port-level checker for the float literal recognizer and its bind statement.
`default_nettype none

module flr_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic                          s_tlast,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [flr_pkg::M_DATA_W-1:0]  m_tdata,
  input  logic                          m_tuser
);
  import flr_pkg::*;

  logic out_held;
  logic in_beat;

  assign out_held = m_tvalid && !m_tready;
  assign in_beat  = s_tvalid && s_tready;

  // Reset leaves no result beat pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A held result beat keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_held |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("held result beat changed");

  // A rejected string carries all-zero fields.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("rejected result has nonzero fields");

  // The last character of a string always yields a result beat next cycle.
  a_last_result: assert property (@(posedge clk) disable iff (rst)
    in_beat && s_tlast |=> m_tvalid)
    else $error("missing result after last beat");

  // A middle character with an empty or draining output yields no result.
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    in_beat && !s_tlast && !out_held |=> !m_tvalid)
    else $error("result beat without a last character");

endmodule

bind float_literal_recognizer flr_checker u_flr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

// File: tb/tb_float_literal_recognizer.sv
// Testbench streaming literal strings through the recognizer and checking each result beat.
`timescale 1ns / 100ps

module tb_float_literal_recognizer;
  import flr_pkg::*;

  // Saturation points of the result fields, kept apart from the design's own constants.
  localparam logic [63:0] SIG_CAP      = 64'd9999999999999999999;
  localparam logic [63:0] SIG_GROW_MAX = 64'd999999999999999999;
  localparam logic [15:0] EXPM_CAP     = 16'hFFFF;
  localparam logic [7:0]  FRAC_CAP     = 8'hFF;
  localparam int          IDLE_LIMIT   = 1000;
  localparam int          RANDOM_CHARS = 390;

  logic                clk = 1'b0;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [CHAR_W-1:0]   s_tdata;   // [7:0] char_code
  logic                s_tlast;   // is_last
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  // [63:0] significand, [71:64] fraction_digits, [72] exponent_negative,
  // [88:73] exponent_magnitude, [89] overflow, [95:90] zero
  logic [M_DATA_W-1:0] m_tdata;
  logic                m_tuser;   // valid_res

  // One scanned literal as the result beat should report it.
  typedef struct {
    bit          ok;
    logic [63:0] sig;
    logic [7:0]  frac;
    bit          neg;
    logic [15:0] expm;
    bit          ovf;
  } literal_t;

  literal_t     pending_literals[$];
  logic [7:0]   word_buf[$];
  int           errors = 0;
  int           chars_sent = 0;
  int           idle_cycles = 0;
  int unsigned  stall_left = 0;
  bit           steady = 1'b0;

  // Scanner state of the predictor.
  bit          first_char;
  bit          in_frac;
  bit          in_exp;
  bit          dot_seen;
  bit          sfx_seen;
  char_class_t prev_cls;
  logic [1:0]  spacer_run;
  bit          rejected;
  bit          mant_seen;
  bit          exp_neg;
  logic [63:0] sig_acc;
  logic [7:0]  frac_cnt;
  logic [15:0] exp_acc;
  bit          sat;

  float_literal_recognizer uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #6 clk = ~clk;

  task clear_scan();
    first_char = 1'b1;
    in_frac    = 1'b0;
    in_exp     = 1'b0;
    dot_seen   = 1'b0;
    sfx_seen   = 1'b0;
    prev_cls   = CLS_NONE;
    spacer_run = 2'd0;
    rejected   = 1'b0;
    mant_seen  = 1'b0;
    exp_neg    = 1'b0;
    sig_acc    = 64'd0;
    frac_cnt   = 8'd0;
    exp_acc    = 16'd0;
    sat        = 1'b0;
  endtask

  // Digits go to the exponent once the mark is seen, else to the significand.
  task scan_digit(input logic [3:0] d);
    int grown;
    if (in_exp) begin
      grown = exp_acc * 10 + d;
      if (grown > EXPM_CAP) begin
        exp_acc = EXPM_CAP;
        sat = 1'b1;
      end else begin
        exp_acc = grown[15:0];
      end
    end else begin
      mant_seen = 1'b1;
      if (sig_acc > SIG_GROW_MAX) begin
        sig_acc = SIG_CAP;
        sat = 1'b1;
      end else begin
        sig_acc = sig_acc * 10 + d;
      end
      // Fraction digits are still counted after the significand has saturated.
      if (in_frac) begin
        if (frac_cnt == FRAC_CAP) sat = 1'b1;
        else frac_cnt = frac_cnt + 8'd1;
      end
    end
  endtask

  // Applies the literal rules to one character; a broken rule rejects the string.
  task scan_char(input logic [7:0] c, input bit is_final);
    char_class_t prior;
    logic [7:0]  digit_off;
    prior = prev_cls;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      digit_off = c - CH_ZERO;
      scan_digit(digit_off[3:0]);
      spacer_run = 2'd0;
      prev_cls = CLS_DIGIT;
    end else if (c == CH_DOT) begin
      if (dot_seen || in_exp || prior == CLS_SPACER) begin
        rejected = 1'b1;
        return;
      end
      dot_seen = 1'b1;
      in_frac = 1'b1;
      prev_cls = CLS_DOT;
    end else if (c == CH_E_LC || c == CH_E_UC) begin
      if (in_exp || prior == CLS_SPACER || first_char || is_final) begin
        rejected = 1'b1;
        return;
      end
      in_exp = 1'b1;
      in_frac = 1'b0;
      prev_cls = CLS_EXP;
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      if (prior != CLS_EXP || is_final) begin
        rejected = 1'b1;
        return;
      end
      exp_neg = (c == CH_MINUS);
      prev_cls = CLS_SIGN;
    end else if (c == CH_UNDER) begin
      if (first_char || is_final || prior == CLS_DOT || prior == CLS_EXP ||
          prior == CLS_SIGN || spacer_run >= 2'd2) begin
        rejected = 1'b1;
        return;
      end
      spacer_run = spacer_run + 2'd1;
      prev_cls = CLS_SPACER;
    end else if (c == CH_F_LC || c == CH_F_UC || c == CH_D_LC || c == CH_D_UC) begin
      if (!is_final || prior == CLS_SPACER || prior == CLS_EXP || prior == CLS_SIGN) begin
        rejected = 1'b1;
        return;
      end
      sfx_seen = 1'b1;
      prev_cls = CLS_SUFFIX;
    end else begin
      rejected = 1'b1;
    end
  endtask

  // Tracks one accepted character beat; the final one queues the expected result.
  task predict_literal(input logic [7:0] c, input bit is_final);
    literal_t lit;
    if (!rejected) scan_char(c, is_final);
    first_char = 1'b0;
    if (is_final) begin
      lit.ok   = !rejected && mant_seen && (dot_seen || in_exp || sfx_seen);
      lit.sig  = lit.ok ? sig_acc : 64'd0;
      lit.frac = lit.ok ? frac_cnt : 8'd0;
      lit.neg  = lit.ok && exp_neg;
      lit.expm = lit.ok ? exp_acc : 16'd0;
      lit.ovf  = lit.ok && sat;
      pending_literals.insert(pending_literals.size(), lit);
      clear_scan();
    end
  endtask

  task compare_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task check_literal();
    literal_t want;
    if (pending_literals.size() == 0) begin
      $display("%0t: result beat with no string pending, actual valid_res %0d", $time, m_tuser);
      errors++;
      return;
    end
    want = pending_literals.pop_front();
    compare_field("valid_res", 64'(want.ok), 64'(m_tuser));
    compare_field("significand", want.sig, m_tdata[SIG_LSB +: SIG_W]);
    compare_field("fraction_digits", 64'(want.frac), 64'(m_tdata[FRAC_LSB +: FRAC_W]));
    compare_field("exponent_negative", 64'(want.neg), 64'(m_tdata[EXPNEG_BIT]));
    compare_field("exponent_magnitude", 64'(want.expm), 64'(m_tdata[EXPM_LSB +: EXPM_W]));
    compare_field("overflow", 64'(want.ovf), 64'(m_tdata[OVF_BIT]));
    compare_field("padding", 64'd0, 64'(m_tdata[M_DATA_W-1:M_USED_W]));
  endtask

  // Both handshakes are sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) predict_literal(s_tdata, s_tlast);
    if (!rst && m_tvalid && m_tready) check_literal();
  end

  // Watchdog on cycles in which no beat moves on either side.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Mostly short pauses, now and then a long one.
  function automatic int pause_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Result side stalls at random unless a steady stretch is running.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready = 1'b0;
      stall_left--;
    end else begin
      m_tready = 1'b1;
      if (!steady && $urandom_range(0, 99) < 30) stall_left = pause_len();
    end
  end

  // Drives one character beat at the falling edge and holds it until accepted.
  task send_char(input logic [7:0] c, input bit is_final);
    int gap;
    gap = (!steady && $urandom_range(0, 99) < 35) ? pause_len() : 0;
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = c;
    s_tlast = is_final;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    chars_sent++;
    @(negedge clk);
  endtask

  // Appends one character to the string being built.
  task add_char(input logic [7:0] c);
    word_buf.insert(word_buf.size(), c);
  endtask

  // Sends the characters already in word_buf followed by tail, as one string.
  task send_literal(input string tail);
    int i;
    for (i = 0; i < tail.len(); i++) add_char(tail[i]);
    for (i = 0; i < word_buf.size(); i++) send_char(word_buf[i], i == word_buf.size() - 1);
    word_buf.delete();
  endtask

  // Digits with an occasional run of underscores between them.
  task put_digits(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      add_char(8'(CH_ZERO + $urandom_range(0, 9)));
      if (i < n - 1 && $urandom_range(0, 99) < 12)
        repeat (($urandom_range(0, 9) == 0) ? 3 : $urandom_range(1, 2))
          add_char(CH_UNDER);
    end
  endtask

  task test_valid_forms();
    send_literal("1.5");
    send_literal("0.");
    send_literal(".5f");
    send_literal("1e10");
    send_literal("2E-3");
    send_literal("7e+0");
    send_literal("9d");
    send_literal("3F");
    send_literal("1_000.25");
    send_literal("4__2.0D");
  endtask

  task test_rule_violations();
    send_literal("1___2.0");
    send_literal("_1.0");
    send_literal("1.0_");
    send_literal("1._5");
    send_literal("1_.5");
    send_literal("e5");
    send_literal("1e");
    send_literal("1e5e2");
    send_literal("1.2.3");
    send_literal("1e2.5");
    send_literal("1_e2");
    send_literal("1e-");
    send_literal("1-2");
    send_literal("+1.0");
    send_literal("1e+-2");
    send_literal("1e_2");
    send_literal("1e-_2");
    send_literal("1f2");
    send_literal("1_f");
    send_literal("1ef");
    send_literal("1e-f");
    send_literal(".e5");
    send_literal("123");
    send_literal("f");
    send_literal("1.x");
    // Characters at both ends of the code range.
    add_char(8'h00);
    send_literal("");
    add_char(8'hFF);
    send_literal("");
  endtask

  task test_saturation();
    // Largest significand that still fits, then one digit too many.
    send_literal("9999999999999999999.");
    send_literal("99999999999999999999.5");
    send_literal("1e65535");
    send_literal("1e65536");
    send_literal("1E-99999");
    // 255 fraction digits fit; a 256th saturates the count.
    add_char(CH_ZERO + 8'd1);
    add_char(CH_DOT);
    repeat (254) add_char(CH_ZERO);
    send_literal("0");
    add_char(CH_ZERO + 8'd1);
    add_char(CH_DOT);
    repeat (255) add_char(CH_ZERO);
    send_literal("0");
  endtask

  // Mostly well-formed literals with random content, some broken by one
  // stray character, and some strings of random bytes.
  task test_random_words();
    int stop_at;
    int kind;
    int n;
    int pos;
    stop_at = chars_sent + RANDOM_CHARS;
    while (chars_sent < stop_at) begin
      if ($urandom_range(0, 99) < 3) steady = !steady;
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        n = $urandom_range(1, 6);
        repeat (n) add_char(8'($urandom_range(0, 255)));
      end else begin
        n = ($urandom_range(0, 99) < 5) ? $urandom_range(18, 22) : $urandom_range(0, 4);
        put_digits(n);
        if ($urandom_range(0, 99) < 60) begin
          add_char(CH_DOT);
          put_digits($urandom_range(0, 4));
        end
        if ($urandom_range(0, 99) < 45) begin
          add_char($urandom_range(0, 1) ? CH_E_LC : CH_E_UC);
          case ($urandom_range(0, 2))
            0: add_char(CH_PLUS);
            1: add_char(CH_MINUS);
            default: ;
          endcase
          put_digits(($urandom_range(0, 99) < 5) ? $urandom_range(5, 6) : $urandom_range(1, 3));
        end
        if ($urandom_range(0, 99) < 30) begin
          case ($urandom_range(0, 3))
            0: add_char(CH_F_LC);
            1: add_char(CH_F_UC);
            2: add_char(CH_D_LC);
            default: add_char(CH_D_UC);
          endcase
        end
        if (word_buf.size() == 0) add_char(8'(CH_ZERO + $urandom_range(0, 9)));
        if (kind >= 85) begin
          pos = $urandom_range(0, word_buf.size() - 1);
          case ($urandom_range(0, 5))
            0: word_buf[pos] = CH_UNDER;
            1: word_buf[pos] = CH_DOT;
            2: word_buf[pos] = CH_E_LC;
            3: word_buf[pos] = CH_MINUS;
            4: word_buf[pos] = CH_F_UC;
            default: word_buf[pos] = 8'($urandom_range(0, 255));
          endcase
        end
      end
      send_literal("");
    end
    steady = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    clear_scan();
    repeat (8) @(negedge clk);
    rst = 1'b0;

    test_valid_forms();
    test_rule_violations();
    test_saturation();
    test_random_words();
    s_tvalid = 1'b0;

    // Drain the outstanding results, then allow time for stray beats.
    while (pending_literals.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/flr_pkg.sv
rtl/core/float_literal_recognizer.sv
rtl/core/flr_checker.sv
tb/tb_float_literal_recognizer.sv
